>>> rtl/best_fit_capacity_allocator_unit_assert.svh
// Assertion macros for the best-fit capacity allocator
`ifndef BEST_FIT_CAPACITY_ALLOCATOR_UNIT_ASSERT_SVH
`define BEST_FIT_CAPACITY_ALLOCATOR_UNIT_ASSERT_SVH

// Implication checked on every clock edge outside reset
`define BFCA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define BFCA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/bfca_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfca_pkg
// Shared types and constants of the best-fit capacity allocator.
// ----------------------------------------------------------------------------
package bfca_pkg;

    localparam int unsigned OPCODE_W   = 2;
    localparam int unsigned STATUS_W   = 2;
    localparam int unsigned NODE_W     = 8;
    localparam int unsigned SOCKET_W   = 8;
    localparam int unsigned FIELD_KB_W = 40;
    localparam int unsigned INDEX_W    = 6;
    localparam int unsigned MIN_W      = 21;
    localparam logic [MIN_W-1:0] MIN_BORROW_RESET = 21'd4096;

    typedef enum logic [OPCODE_W-1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_ASSIGN = 2'd2,
        OP_QUERY  = 2'd3
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_NOFIT = 2'd1,
        ST_FULL  = 2'd2,
        ST_RSVD  = 2'd3
    } status_t;

    localparam logic [0:0] REG_MIN_BORROW = 1'b0;

    // Filter and fit settings held for the head-cell comparison during a scan
    typedef struct packed {
        logic                is_assign;
        logic [NODE_W-1:0]   borrower;
        logic                constrained;
        logic [SOCKET_W-1:0] socket;
    } bfca_scan_t;

endpackage

>>> rtl/bfca_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfca_in_if
// Input item channel.
// ----------------------------------------------------------------------------
interface bfca_in_if
    import bfca_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [OPCODE_W-1:0]   opcode;
    logic [NODE_W-1:0]     entry_node;
    logic [SOCKET_W-1:0]   entry_socket;
    logic [FIELD_KB_W-1:0] entry_capacity_kb;
    logic [NODE_W-1:0]     borrower_node;
    logic                  socket_constrained;
    logic [SOCKET_W-1:0]   required_socket;
    logic [FIELD_KB_W-1:0] demand_kb;

    modport source (output valid, opcode, entry_node, entry_socket, entry_capacity_kb,
                    borrower_node, socket_constrained, required_socket, demand_kb,
                    input ready);
    modport sink (input valid, opcode, entry_node, entry_socket, entry_capacity_kb,
                  borrower_node, socket_constrained, required_socket, demand_kb,
                  output ready);
endinterface

>>> rtl/bfca_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfca_out_if
// Result item channel.
// ----------------------------------------------------------------------------
interface bfca_out_if
    import bfca_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [STATUS_W-1:0]   status;
    logic [NODE_W-1:0]     lender_node;
    logic [INDEX_W-1:0]    chosen_index;
    logic [FIELD_KB_W-1:0] remaining_kb;
    logic [FIELD_KB_W-1:0] largest_kb;

    modport source (output valid, status, lender_node, chosen_index, remaining_kb,
                    largest_kb, input ready);
    modport sink (input valid, status, lender_node, chosen_index, remaining_kb,
                  largest_kb, output ready);
endinterface

>>> rtl/bfca_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfca_cell
// One table entry. Entries form a ring: during a scan every cell passes its
// contents to its neighbor each cycle, so the head cell sees entries in order.
// ----------------------------------------------------------------------------
module bfca_cell
    import bfca_pkg::*;
#(
    parameter int unsigned CAP_W = 40
)
(
    input  logic                clk,
    input  logic                shift,     // rotate one place
    input  logic                load,      // load local value (append/update at this cell)
    input  logic [NODE_W-1:0]   node_in,
    input  logic [SOCKET_W-1:0] socket_in,
    input  logic [CAP_W-1:0]    cap_in,
    output logic [NODE_W-1:0]   node,
    output logic [SOCKET_W-1:0] socket,
    output logic [CAP_W-1:0]    cap
);
    logic [NODE_W-1:0]   node_reg;
    logic [SOCKET_W-1:0] socket_reg;
    logic [CAP_W-1:0]    cap_reg;

    always_ff @(posedge clk)
    begin
        if (shift || load)
        begin
            node_reg   <= node_in;
            socket_reg <= socket_in;
            cap_reg    <= cap_in;
        end
    end

    assign node   = node_reg;
    assign socket = socket_reg;
    assign cap    = cap_reg;
endmodule

>>> rtl/best_fit_capacity_allocator_unit.sv
`timescale 1ns / 1ps
// Sequence: clear and append raise the result straight from the accept. Query, and
// assign with no fitting entry, scan the ring and then present the result. Assign
// that finds an entry passes through a write-back state (S_FIX) before the result.
// Throughput: one item at a time; the next item is accepted once the result is taken.
// The ring rotates one entry per cycle through the head cell, so a scan is one lap.
// Reset: rst_n asynchronous, active low; empties the table, min borrow = 4096.
// ----------------------------------------------------------------------------
// best_fit_capacity_allocator_unit
// Best-fit lender table built as a rotating ring of entry cells.
// ----------------------------------------------------------------------------
module best_fit_capacity_allocator_unit
    import bfca_pkg::*;
#(
    parameter int unsigned TABLE_ENTRIES = 64,
    parameter int unsigned CAPACITY_BITS = 40
)
(
    input  logic         clk,
    input  logic         rst_n,
    bfca_in_if.sink      in_ch,
    bfca_out_if.source   out_ch,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [1:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    `include "best_fit_capacity_allocator_unit_assert.svh"

    localparam int unsigned N   = TABLE_ENTRIES;
    localparam int unsigned IW  = $clog2(N);        // entry index
    localparam int unsigned CW  = $clog2(N + 1);    // fill count
    localparam int unsigned CAP = CAPACITY_BITS;
    // Compare width: holds any capacity and any 40-bit need
    localparam int unsigned XW  = (CAP > FIELD_KB_W) ? CAP : FIELD_KB_W;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_FIX  = 4'b0100,
        S_OUT  = 4'b1000
    } state_t;

    // ---------------- configuration ----------------
    logic [MIN_W-1:0] min_reg;
    assign pready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            min_reg <= MIN_BORROW_RESET;
        else if (psel && penable && pwrite && paddr[1] == REG_MIN_BORROW)
            min_reg <= pwdata[MIN_W-1:0];
    end
    assign prdata = (paddr[1] == REG_MIN_BORROW) ? {{(32-MIN_W){1'b0}}, min_reg} : 32'd0;

    // ---------------- control ----------------
    state_t           state_reg, state_next;
    logic [CW-1:0]    count_reg;
    logic [IW:0]      step_reg;     // scan position (head index), counts to N
    logic [IW-1:0]    best_reg;
    logic             found_reg;
    logic [XW-1:0]    best_cap_reg;
    logic [XW-1:0]    need_reg;
    bfca_scan_t       scan_reg;

    // ring of cells; cell 0 is the head, cells hand data to index-1
    logic [NODE_W-1:0]   c_node   [N];
    logic [SOCKET_W-1:0] c_socket [N];
    logic [CAP-1:0]      c_cap    [N];
    logic                shift;

    // Entry k lives at cell k when the ring is at rest. Append writes cell
    // count directly (one write port, index by count).
    logic [IW-1:0] app_idx;
    assign app_idx = count_reg[IW-1:0];

    logic in_fire, out_fire, scan_last;
    assign in_fire   = in_ch.valid && in_ch.ready;
    assign out_fire  = out_ch.valid && out_ch.ready;
    assign in_ch.ready = (state_reg == S_IDLE) && !out_ch.valid;
    assign shift     = (state_reg == S_SCAN);
    assign scan_last = (step_reg == (IW+1)'(N - 1));

    // head cell view
    logic head_live, head_qual, head_fit, head_better;
    logic [XW-1:0] head_cap_x;
    assign head_cap_x  = XW'(c_cap[0]);
    assign head_live   = (step_reg < (IW+1)'(count_reg));
    assign head_qual   = head_live && (c_node[0] != scan_reg.borrower)
                      && (!scan_reg.constrained || c_socket[0] == scan_reg.socket);
    assign head_fit    = scan_reg.is_assign ? (head_cap_x >= need_reg) : 1'b1;
    assign head_better = !found_reg ||
                         (scan_reg.is_assign ? (head_cap_x < best_cap_reg)
                                             : (head_cap_x > best_cap_reg));

    // head entry becomes the new candidate
    logic hit;
    assign hit = head_qual && head_fit && head_better;

    // deduction performed at the chosen cell once the ring is back at rest
    logic [XW-1:0] fix_cap;
    assign fix_cap = best_cap_reg - need_reg;

    genvar g;
    generate
        for (g = 0; g < N; g++)
        begin : g_ring
            logic                ld;
            logic [NODE_W-1:0]   n_in;
            logic [SOCKET_W-1:0] s_in;
            logic [CAP-1:0]      k_in;
            always_comb
            begin
                ld   = 1'b0;
                n_in = c_node[(g + 1) % N];
                s_in = c_socket[(g + 1) % N];
                k_in = c_cap[(g + 1) % N];
                if (state_reg == S_IDLE && in_fire && in_ch.opcode == OP_APPEND
                    && count_reg < CW'(N) && app_idx == IW'(g))
                begin
                    ld   = 1'b1;
                    n_in = in_ch.entry_node;
                    s_in = in_ch.entry_socket;
                    k_in = CAP'(in_ch.entry_capacity_kb);
                end
                else if (state_reg == S_FIX && best_reg == IW'(g))
                begin
                    ld   = 1'b1;
                    n_in = c_node[g];
                    s_in = c_socket[g];
                    k_in = CAP'(fix_cap);
                end
            end
            bfca_cell #(.CAP_W(CAP)) u_cell (
                .clk      (clk),
                .shift    (shift),
                .load     (ld),
                .node_in  (n_in),
                .socket_in(s_in),
                .cap_in   (k_in),
                .node     (c_node[g]),
                .socket   (c_socket[g]),
                .cap      (c_cap[g])
            );
        end
    endgenerate

    // result register
    logic                  ov_reg;
    logic [STATUS_W-1:0]   ost_reg;
    logic [NODE_W-1:0]     onode_reg;
    logic [INDEX_W-1:0]    oidx_reg;
    logic [FIELD_KB_W-1:0] orem_reg;
    logic [FIELD_KB_W-1:0] olarge_reg;
    logic [NODE_W-1:0]     best_node_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (in_fire && (in_ch.opcode == OP_ASSIGN || in_ch.opcode == OP_QUERY))
                        state_next = S_SCAN;
            // a hit on the last entry counts before found_reg catches it
            S_SCAN: if (scan_last)
                        state_next = (scan_reg.is_assign && (found_reg || hit)) ? S_FIX : S_OUT;
            S_FIX:  state_next = S_OUT;
            S_OUT:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            step_reg  <= '0;
            found_reg <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_fire)
                ov_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        step_reg  <= '0;
                        found_reg <= 1'b0;
                        unique case (opcode_t'(in_ch.opcode))
                            OP_CLEAR:
                            begin
                                count_reg <= '0;
                                ov_reg    <= 1'b1;
                            end
                            OP_APPEND:
                            begin
                                if (count_reg < CW'(N))
                                    count_reg <= count_reg + 1'b1;
                                ov_reg <= 1'b1;
                            end
                            default: ;
                        endcase
                    end
                end
                S_SCAN:
                begin
                    step_reg <= step_reg + 1'b1;
                    if (hit)
                        found_reg <= 1'b1;
                end
                S_FIX: ;
                S_OUT: ov_reg <= 1'b1;
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_fire)
        begin
            scan_reg.is_assign   <= (in_ch.opcode == OP_ASSIGN);
            scan_reg.borrower    <= in_ch.borrower_node;
            scan_reg.constrained <= in_ch.socket_constrained;
            scan_reg.socket      <= in_ch.required_socket;
            need_reg     <= (in_ch.demand_kb < FIELD_KB_W'(min_reg))
                            ? XW'(min_reg) : XW'(in_ch.demand_kb);
            best_cap_reg <= '0;
            ost_reg      <= (in_ch.opcode == OP_APPEND && count_reg >= CW'(N))
                            ? ST_FULL : ST_OK;
            onode_reg    <= '0;
            oidx_reg     <= '0;
            orem_reg     <= '0;
            olarge_reg   <= '0;
        end
        else if (state_reg == S_SCAN && hit)
        begin
            best_reg      <= step_reg[IW-1:0];
            best_cap_reg  <= head_cap_x;
            best_node_reg <= c_node[0];
        end
        else if (state_reg == S_OUT)
        begin
            if (scan_reg.is_assign)
            begin
                if (found_reg)
                begin
                    ost_reg   <= ST_OK;
                    onode_reg <= best_node_reg;
                    oidx_reg  <= INDEX_W'(best_reg);
                    orem_reg  <= FIELD_KB_W'(CAP'(best_cap_reg - need_reg));
                end
                else
                    ost_reg <= ST_NOFIT;
            end
            else
                olarge_reg <= (found_reg && best_cap_reg >= XW'(min_reg))
                              ? FIELD_KB_W'(best_cap_reg) : '0;
        end
    end

    assign out_ch.valid        = ov_reg;
    assign out_ch.status       = ost_reg;
    assign out_ch.lender_node  = onode_reg;
    assign out_ch.chosen_index = oidx_reg;
    assign out_ch.remaining_kb = orem_reg;
    assign out_ch.largest_kb   = olarge_reg;

    // ---------------- assertions ----------------
    `BFCA_ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, count_reg <= CW'(N), "count over depth")
    `BFCA_ASSERT_IMPL(a_no_accept_busy, clk, rst_n, state_reg != S_IDLE, !in_ch.ready,
        "accept while busy")
    `BFCA_ASSERT_NEXT(a_scan_ends, clk, rst_n, state_reg == S_SCAN && scan_last,
        state_reg == S_FIX || state_reg == S_OUT, "scan overrun")
    `BFCA_ASSERT_NEXT(a_out_valid, clk, rst_n, state_reg == S_OUT, out_ch.valid,
        "result not raised")
endmodule

>>> test/tb_best_fit_capacity_allocator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_best_fit_capacity_allocator_unit
// Self-checking bench for the best-fit lender table. A directed table walks the
// corner cases, then random clear/append/assign/query sequences run under
// several minimum borrow settings, with bursty input and a stalling output.
// Every result is checked field by field against a typed answer or a local table model.
// ----------------------------------------------------------------------------
module tb_best_fit_capacity_allocator_unit;
    import bfca_pkg::*;

    localparam int unsigned ENTRIES    = 64;
    localparam int unsigned SCAN_WAIT  = ENTRIES + 8;   // drain margin past one scan
    localparam int unsigned IDLE_LIMIT = 4000;          // watchdog, cycles without an item
    localparam int unsigned LONG_HOLD  = 400;
    localparam int unsigned RAND_ITEMS = 250;           // per configuration phase
    localparam logic [1:0]  ADDR_MIN_BORROW = 2'(REG_MIN_BORROW) << 2;
    localparam logic [39:0] ALL_ONES = '1;

    typedef struct {
        opcode_t     op;
        logic [7:0]  node;
        logic [7:0]  sock;
        logic [39:0] cap;
        logic [7:0]  borrower;
        logic        constrained;
        logic [7:0]  req_sock;
        logic [39:0] demand;
    } alloc_req_t;

    typedef struct {
        status_t     status;
        logic [7:0]  lender;
        logic [5:0]  index;
        logic [39:0] remaining;
        logic [39:0] largest;
    } alloc_resp_t;

    // Directed row: request fields, then whether the answer is typed in, then the answer
    typedef struct {
        opcode_t     op;
        logic [7:0]  node;
        logic [7:0]  sock;
        logic [39:0] cap;
        logic [7:0]  borrower;
        logic        constrained;
        logic [7:0]  req_sock;
        logic [39:0] demand;
        bit          typed;
        status_t     status;
        logic [7:0]  lender;
        logic [5:0]  index;
        logic [39:0] remaining;
        logic [39:0] largest;
    } dir_row_t;

    logic clk;
    logic rst_n;
    logic psel, penable, pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    bfca_in_if  in_ch ();
    bfca_out_if out_ch ();

    best_fit_capacity_allocator_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Local copy of the lender table and the minimum borrow register
    logic [7:0]  tbl_node [ENTRIES];
    logic [7:0]  tbl_sock [ENTRIES];
    logic [39:0] tbl_cap  [ENTRIES];
    int unsigned tbl_count;
    logic [39:0] min_borrow;

    alloc_resp_t pending_resp [$];
    int unsigned error_count;
    int unsigned idle_cycles;
    bit          long_hold_req;
    int unsigned burst_left;

    // Corner cases at the default minimum of 4096
    dir_row_t dir_rows [14] = '{
        // empty table: query answers zero, assign finds nothing
        '{OP_QUERY,  8'd0,  8'd0,  40'd0,     8'd0,  1'b0, 8'd0,  40'd0,
          1, ST_OK,    8'd0, 6'd0, 40'd0, 40'd0},
        '{OP_ASSIGN, 8'd0,  8'd0,  40'd0,     8'd0,  1'b0, 8'd0,  40'd100,
          1, ST_NOFIT, 8'd0, 6'd0, 40'd0, 40'd0},
        '{OP_APPEND, 8'd1,  8'd0,  40'd10000, 8'd0,  1'b0, 8'd0,  40'd0,
          1, ST_OK,    8'd0, 6'd0, 40'd0, 40'd0},
        '{OP_APPEND, 8'd2,  8'd1,  40'd5000,  8'd0,  1'b0, 8'd0,  40'd0,
          1, ST_OK,    8'd0, 6'd0, 40'd0, 40'd0},
        '{OP_APPEND, 8'd3,  8'd1,  40'd5000,  8'd0,  1'b0, 8'd0,  40'd0,
          1, ST_OK,    8'd0, 6'd0, 40'd0, 40'd0},
        '{OP_APPEND, 8'hFF, 8'hFF, ALL_ONES,  8'd0,  1'b0, 8'd0,  40'd0,
          1, ST_OK,    8'd0, 6'd0, 40'd0, 40'd0},
        // zero demand rounds up; tie at 5000 goes to the lower index
        '{OP_ASSIGN, 8'd0,  8'd0,  40'd0,     8'd0,  1'b0, 8'd0,  40'd0,
          0, ST_OK,    8'd0, 6'd0, 40'd0, 40'd0},
        // own entry skipped under a socket constraint
        '{OP_ASSIGN, 8'd0,  8'd0,  40'd0,     8'd2,  1'b1, 8'd1,  40'd4000,
          0, ST_OK,    8'd0, 6'd0, 40'd0, 40'd0},
        // everything filtered out
        '{OP_ASSIGN, 8'd0,  8'd0,  40'd0,     8'hFF, 1'b1, 8'hFF, 40'd1,
          1, ST_NOFIT, 8'd0, 6'd0, 40'd0, 40'd0},
        '{OP_QUERY,  8'd0,  8'd0,  40'd0,     8'd0,  1'b0, 8'd0,  40'd0,
          1, ST_OK,    8'd0, 6'd0, 40'd0, ALL_ONES},
        // socket 1 leftovers are below the minimum
        '{OP_QUERY,  8'd0,  8'd0,  40'd0,     8'd0,  1'b1, 8'd1,  40'd0,
          1, ST_OK,    8'd0, 6'd0, 40'd0, 40'd0},
        // full-width demand drains the full-width entry
        '{OP_ASSIGN, 8'd0,  8'd0,  40'd0,     8'd0,  1'b0, 8'd0,  ALL_ONES,
          1, ST_OK,    8'hFF, 6'd3, 40'd0, 40'd0},
        '{OP_CLEAR,  8'hFF, 8'hFF, ALL_ONES,  8'hFF, 1'b1, 8'hFF, ALL_ONES,
          1, ST_OK,    8'd0, 6'd0, 40'd0, 40'd0},
        '{OP_QUERY,  8'd0,  8'd0,  40'd0,     8'd0,  1'b0, 8'd0,  40'd0,
          1, ST_OK,    8'd0, 6'd0, 40'd0, 40'd0}
    };

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = ~clk;
        end
    end

    // Best-fit table model; updates the local table as the block would
    function automatic alloc_resp_t predict_alloc(input alloc_req_t rq);
        alloc_resp_t r;
        logic [39:0] need;
        logic [39:0] largest;
        bit          found;
        int unsigned best;
        bit          ok;
        r = '{ST_OK, 8'd0, 6'd0, 40'd0, 40'd0};
        found = 0;
        best = 0;
        largest = '0;
        need = (rq.demand < min_borrow) ? min_borrow : rq.demand;
        case (rq.op)
            OP_CLEAR:
                tbl_count = 0;
            OP_APPEND:
                if (tbl_count >= ENTRIES)
                    r.status = ST_FULL;
                else
                begin
                    tbl_node[tbl_count] = rq.node;
                    tbl_sock[tbl_count] = rq.sock;
                    tbl_cap[tbl_count]  = rq.cap;
                    tbl_count++;
                end
            default:
            begin
                for (int unsigned i = 0; i < tbl_count; i++)
                begin
                    ok = (tbl_node[i] != rq.borrower) &&
                         (!rq.constrained || tbl_sock[i] == rq.req_sock);
                    if (rq.op == OP_ASSIGN)
                    begin
                        if (ok && tbl_cap[i] >= need && (!found || tbl_cap[i] < tbl_cap[best]))
                        begin
                            best = i;
                            found = 1;
                        end
                    end
                    else if (ok && tbl_cap[i] > largest)
                        largest = tbl_cap[i];
                end
                if (rq.op == OP_ASSIGN)
                begin
                    if (!found)
                        r.status = ST_NOFIT;
                    else
                    begin
                        tbl_cap[best] = tbl_cap[best] - need;
                        r.lender    = tbl_node[best];
                        r.index     = best[5:0];
                        r.remaining = tbl_cap[best];
                    end
                end
                else
                    r.largest = (largest < min_borrow) ? 40'd0 : largest;
            end
        endcase
        return r;
    endfunction

    // APB write (setup, then access until pready); the block is idle whenever this is called
    task automatic write_min_borrow(input logic [20:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_MIN_BORROW;
        pwdata  <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        min_borrow = 40'(value);
    endtask

    // Offer one item. Gaps between bursts drop valid; inside a burst valid
    // stays high straight into the next item.
    task automatic offer_item(input alloc_req_t rq, input bit typed, input alloc_resp_t typed_resp);
        alloc_resp_t r;
        if (burst_left == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
            // occasionally a long burst with no gaps at all
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 8);
        end
        burst_left--;
        in_ch.valid              <= 1'b1;
        in_ch.opcode             <= rq.op;
        in_ch.entry_node         <= rq.node;
        in_ch.entry_socket       <= rq.sock;
        in_ch.entry_capacity_kb  <= rq.cap;
        in_ch.borrower_node      <= rq.borrower;
        in_ch.socket_constrained <= rq.constrained;
        in_ch.required_socket    <= rq.req_sock;
        in_ch.demand_kb          <= rq.demand;
        do
            @(posedge clk);
        while (!in_ch.ready);
        r = predict_alloc(rq);
        pending_resp.insert(pending_resp.size(), typed ? typed_resp : r);
    endtask

    // Drop valid and wait until the block has answered everything
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        burst_left = 0;
        while (pending_resp.size() != 0)
            @(posedge clk);
        repeat (SCAN_WAIT) @(posedge clk);
    endtask

    function automatic logic [39:0] rand_kb();
        case ($urandom_range(0, 5))
            0:       return 40'({$urandom, $urandom});
            1, 2:    return 40'($urandom_range(0, 4_000_000));
            default: return 40'($urandom_range(0, 20_000));
        endcase
    endfunction

    function automatic alloc_req_t rand_req(input opcode_t op);
        alloc_req_t rq;
        // small node/socket ranges so the filters hit often; full range now and then
        rq.op          = op;
        rq.node        = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 5));
        rq.sock        = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 2));
        rq.cap         = rand_kb();
        rq.borrower    = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 5));
        rq.constrained = 1'($urandom);
        rq.req_sock    = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 2));
        rq.demand      = rand_kb();
        return rq;
    endfunction

    // Mostly well-formed sequences: clear, fill, then assign/query; some noise
    task automatic run_random(input int unsigned n_items);
        alloc_resp_t dummy;
        int unsigned sent;
        int unsigned fill;
        dummy = '{ST_OK, 8'd0, 6'd0, 40'd0, 40'd0};
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(0, 5) == 0)
            begin
                offer_item(rand_req(opcode_t'($urandom_range(0, 3))), 0, dummy);
                sent++;
            end
            else
            begin
                offer_item(rand_req(OP_CLEAR), 0, dummy);
                // now and then overfill to reach the table-full answer
                fill = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 12);
                repeat (fill) offer_item(rand_req(OP_APPEND), 0, dummy);
                repeat ($urandom_range(3, 15))
                    offer_item(rand_req($urandom_range(0, 2) != 0 ? OP_ASSIGN : OP_QUERY), 0, dummy);
                sent += fill + 1;
            end
        end
    endtask

    // Result side: check against the oldest expectation, then pick next ready
    initial
    begin
        int unsigned hold;
        alloc_resp_t e;
        hold = 0;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_ch.valid && out_ch.ready)
            begin
                if (pending_resp.size() == 0)
                begin
                    $error("result with no item outstanding");
                    error_count++;
                end
                else
                begin
                    e = pending_resp.pop_front();
                    if (out_ch.status !== e.status)
                    begin
                        $error("status: expected %0d, got %0d", e.status, out_ch.status);
                        error_count++;
                    end
                    if (out_ch.lender_node !== e.lender)
                    begin
                        $error("lender_node: expected %0d, got %0d", e.lender, out_ch.lender_node);
                        error_count++;
                    end
                    if (out_ch.chosen_index !== e.index)
                    begin
                        $error("chosen_index: expected %0d, got %0d", e.index, out_ch.chosen_index);
                        error_count++;
                    end
                    if (out_ch.remaining_kb !== e.remaining)
                    begin
                        $error("remaining_kb: expected %0d, got %0d", e.remaining,
                               out_ch.remaining_kb);
                        error_count++;
                    end
                    if (out_ch.largest_kb !== e.largest)
                    begin
                        $error("largest_kb: expected %0d, got %0d", e.largest, out_ch.largest_kb);
                        error_count++;
                    end
                end
            end
            if (long_hold_req)
            begin
                long_hold_req = 0;
                hold = LONG_HOLD;
            end
            else if (hold == 0 && $urandom_range(0, 19) == 0)
                hold = $urandom_range(1, 6);
            if (hold != 0)
            begin
                hold--;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    // Watchdog: too long without any item moving on either channel
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb_best_fit_capacity_allocator_unit: errors");
            $finish;
        end
    end

    initial
    begin
        alloc_req_t  rq;
        alloc_resp_t er;
        logic [20:0] phase_min [4];
        phase_min   = '{21'd4096, 21'd1, 21'd1048576, 21'd0};
        error_count = 0;
        idle_cycles = 0;
        long_hold_req = 0;
        burst_left  = 0;
        tbl_count   = 0;
        min_borrow  = 40'(MIN_BORROW_RESET);
        rst_n   <= 1'b0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        in_ch.valid              <= 1'b0;
        in_ch.opcode             <= OP_CLEAR;
        in_ch.entry_node         <= '0;
        in_ch.entry_socket       <= '0;
        in_ch.entry_capacity_kb  <= '0;
        in_ch.borrower_node      <= '0;
        in_ch.socket_constrained <= 1'b0;
        in_ch.required_socket    <= '0;
        in_ch.demand_kb          <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows run at the reset minimum
        foreach (dir_rows[i])
        begin
            rq = '{dir_rows[i].op, dir_rows[i].node, dir_rows[i].sock, dir_rows[i].cap,
                   dir_rows[i].borrower, dir_rows[i].constrained, dir_rows[i].req_sock,
                   dir_rows[i].demand};
            er = '{dir_rows[i].status, dir_rows[i].lender, dir_rows[i].index,
                   dir_rows[i].remaining, dir_rows[i].largest};
            offer_item(rq, dir_rows[i].typed, er);
        end

        // Random phases under several minimum borrow settings
        phase_min[3] = 21'($urandom_range(1, 1048576));
        foreach (phase_min[p])
        begin
            drain_results();
            write_min_borrow(phase_min[p]);
            if (p == 1)
                long_hold_req = 1;   // output blocked while input keeps offering
            run_random(RAND_ITEMS);
        end

        in_ch.valid <= 1'b0;
        while (pending_resp.size() != 0)
            @(posedge clk);
        repeat (SCAN_WAIT) @(posedge clk);
        if (error_count == 0)
            $display("tb_best_fit_capacity_allocator_unit: clean");
        else
            $display("tb_best_fit_capacity_allocator_unit: errors");
        $finish;
    end

endmodule
